// ===== rtl/core/bds_pkg.sv =====
package bds_pkg;

  localparam int unsigned FACTOR_W     = 5;
  localparam int unsigned DIM_W        = 13;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 13;
  localparam int unsigned PIX_W        = 8;
  localparam int unsigned HEIGHT_LIMIT = 4096;
  localparam int unsigned QUEUE_DEPTH  = 4;

  localparam int unsigned DEF_MAX_WIDTH  = 4096;
  localparam int unsigned DEF_MAX_FACTOR = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [FACTOR_W-1:0] FACTOR_RST = 5'd2;
  localparam logic [DIM_W-1:0]    WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]    HEIGHT_RST = 13'd480;

  // per-pixel flags handed from front to back
  typedef struct packed {
    logic first;
    logic emit;
    logic done;
  } flags_t;

  localparam int unsigned FLAGS_W = $bits(flags_t);

endpackage

// ===== rtl/core/bds_ram.sv =====
module bds_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bds_fifo.sv =====
module bds_fifo #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/core/bds_front.sv =====
module bds_front #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_FACTOR = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bds_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bds_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [bds_pkg::PIX_W-1:0]       red_in_i,
  input  logic [bds_pkg::PIX_W-1:0]       green_in_i,
  input  logic [bds_pkg::PIX_W-1:0]       blue_in_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output logic [bds_pkg::FLAGS_W+$clog2(MAX_WIDTH)+3*bds_pkg::PIX_W-1:0] q_data_o,
  output logic [2*$clog2(MAX_FACTOR+1)-1:0] area_o
);
  import bds_pkg::*;

  localparam int unsigned AW     = $clog2(MAX_WIDTH);
  localparam int unsigned OCW    = $clog2(MAX_WIDTH+1);
  localparam int unsigned FW     = $clog2(MAX_FACTOR+1);
  localparam int unsigned AREA_W = 2*FW;
  localparam int unsigned DCW    = $clog2(DIM_W);

  typedef enum logic [1:0] {D_IDLE, D_W, D_H} dstate_e;

  logic [FACTOR_W-1:0] factor_q;
  logic [DIM_W-1:0]    width_q, height_q;
  logic [FW-1:0]       f_eff;
  logic [DIM_W-1:0]    w_eff, h_eff;

  dstate_e             dst_q;
  logic [DCW-1:0]      dcnt_q;
  logic [FW:0]         drem_q, dt, drem_n;
  logic                dbit;
  logic [DIM_W-1:0]    used_w_q, used_h_q;
  logic [AREA_W-1:0]   area_q;

  logic [DIM_W-1:0]    col_q, row_q;
  logic [FW-1:0]       cib_q, rib_q;
  logic [OCW-1:0]      oc_q;
  logic                accept, act, lastc, lastr;
  flags_t              flags;

  // effective settings after range clamping
  always_comb begin
    if (factor_q == '0) begin
      f_eff = FW'(1);
    end else if (32'(factor_q) > MAX_FACTOR) begin
      f_eff = FW'(MAX_FACTOR);
    end else begin
      f_eff = FW'(factor_q);
    end
    if (width_q == '0) begin
      w_eff = DIM_W'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = DIM_W'(1);
    end else if (32'(height_q) > HEIGHT_LIMIT) begin
      h_eff = DIM_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = height_q;
    end
  end

  // bit-serial remainder of width and height by the factor
  assign dbit   = (dst_q == D_H) ? h_eff[dcnt_q] : w_eff[dcnt_q];
  assign dt     = {drem_q[FW-1:0], dbit};
  assign drem_n = (dt >= {1'b0, f_eff}) ? dt - {1'b0, f_eff} : dt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= FACTOR_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      dst_q    <= D_W;
      dcnt_q   <= DCW'(DIM_W-1);
      drem_q   <= '0;
      used_w_q <= '0;
      used_h_q <= '0;
      area_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FACTOR: factor_q <= cfg_data_i[FACTOR_W-1:0];
        CFG_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
      dst_q  <= D_W;
      dcnt_q <= DCW'(DIM_W-1);
      drem_q <= '0;
    end else begin
      case (dst_q)
        D_W: begin
          drem_q <= drem_n;
          if (dcnt_q == '0) begin
            used_w_q <= w_eff - DIM_W'(drem_n);
            dst_q    <= D_H;
            dcnt_q   <= DCW'(DIM_W-1);
            drem_q   <= '0;
          end else begin
            dcnt_q <= dcnt_q - 1'b1;
          end
        end
        D_H: begin
          drem_q <= drem_n;
          if (dcnt_q == '0) begin
            used_h_q <= h_eff - DIM_W'(drem_n);
            area_q   <= {FW'(0), f_eff} * {FW'(0), f_eff};
            dst_q    <= D_IDLE;
          end else begin
            dcnt_q <= dcnt_q - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_stall_o = (dst_q != D_IDLE) || q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign lastc = ({1'b0, cib_q} + 1'b1) >= {1'b0, f_eff};
  assign lastr = ({1'b0, rib_q} + 1'b1) >= {1'b0, f_eff};
  assign act   = (col_q < used_w_q) && (row_q < used_h_q) && (32'(oc_q) < MAX_WIDTH);

  assign flags.first = (rib_q == '0) && (cib_q == '0);
  assign flags.emit  = lastr && lastc;
  assign flags.done  = (({1'b0, row_q} + 1'b1) >= {1'b0, used_h_q})
                    && (({1'b0, col_q} + 1'b1) >= {1'b0, used_w_q});

  assign q_push_o = accept && act;
  assign q_data_o = {flags, oc_q[AW-1:0], red_in_i, green_in_i, blue_in_i};
  assign area_o   = area_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [DIM_W:0] col_n, row_n;
    logic [OCW:0]   oc_n;
    logic [FW-1:0]  cib_n, rib_n;
    logic [DIM_W-1:0] col_v, row_v;
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      cib_q <= '0;
      rib_q <= '0;
      oc_q  <= '0;
    end else if (accept) begin
      col_n = {1'b0, col_q} + 1'b1;
      row_n = {1'b0, row_q} + 1'b1;
      rib_n = rib_q;
      row_v = row_q;
      if (lastc) begin
        cib_n = '0;
        oc_n  = {1'b0, oc_q} + 1'b1;
      end else begin
        cib_n = cib_q + 1'b1;
        oc_n  = {1'b0, oc_q};
      end
      col_v = col_n[DIM_W-1:0];
      if (col_n >= {1'b0, w_eff}) begin
        col_v = '0;
        cib_n = '0;
        oc_n  = '0;
        rib_n = lastr ? '0 : rib_q + 1'b1;
        row_v = row_n[DIM_W-1:0];
        if (row_n >= {1'b0, h_eff}) begin
          row_v = '0;
          rib_n = '0;
        end
      end
      if (32'(oc_n) > MAX_WIDTH) begin
        oc_n = (OCW+1)'(MAX_WIDTH);
      end
      col_q <= col_v;
      row_q <= row_v;
      cib_q <= cib_n;
      rib_q <= rib_n;
      oc_q  <= oc_n[OCW-1:0];
    end
  end

endmodule

// ===== rtl/core/bds_back.sv =====
module bds_back #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_FACTOR = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  input  logic [bds_pkg::FLAGS_W+$clog2(MAX_WIDTH)+3*bds_pkg::PIX_W-1:0] q_data_i,
  output logic                          q_pop_o,
  input  logic [2*$clog2(MAX_FACTOR+1)-1:0] area_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bds_pkg::PIX_W-1:0]     red_out_o,
  output logic [bds_pkg::PIX_W-1:0]     green_out_o,
  output logic [bds_pkg::PIX_W-1:0]     blue_out_o,
  output logic                          frame_done_o
);
  import bds_pkg::*;

  localparam int unsigned AW     = $clog2(MAX_WIDTH);
  localparam int unsigned FW     = $clog2(MAX_FACTOR+1);
  localparam int unsigned AREA_W = 2*FW;
  localparam int unsigned REM_W  = AREA_W+1;
  localparam int unsigned SUM_W  = PIX_W + 2*$clog2(MAX_FACTOR);
  localparam int unsigned HI_W   = SUM_W - PIX_W;
  localparam int unsigned EW     = FLAGS_W + AW + 3*PIX_W;
  localparam int unsigned CW     = $clog2(PIX_W);

  typedef enum logic [1:0] {S_IDLE, S_ACC, S_DIV, S_OUT} state_e;

  state_e              state_q;
  logic [EW-1:0]       cur_q;
  flags_t              cur_flags;
  logic [AW-1:0]       cur_addr;
  logic [PIX_W-1:0]    cur_pix [3];
  logic [SUM_W-1:0]    old_sum [3];
  logic [SUM_W-1:0]    new_sum [3];
  logic [SUM_W-1:0]    sum_q [3];
  logic [REM_W-1:0]    rem_q [3];
  logic [REM_W-1:0]    trial [3];
  logic [PIX_W-1:0]    quo_q [3];
  logic [2:0]          sat_q;
  logic [CW-1:0]       cnt_q;
  logic [REM_W-1:0]    area_ext;
  logic [3*SUM_W-1:0]  ram_rdata;
  logic                ram_we;
  logic                out_valid_q, done_q;
  logic [PIX_W-1:0]    out_q [3];

  assign cur_flags  = cur_q[EW-1 -: FLAGS_W];
  assign cur_addr   = cur_q[3*PIX_W +: AW];
  assign cur_pix[0] = cur_q[2*PIX_W +: PIX_W];
  assign cur_pix[1] = cur_q[PIX_W +: PIX_W];
  assign cur_pix[2] = cur_q[0 +: PIX_W];
  assign area_ext   = REM_W'(area_i);

  assign q_pop_o = (state_q == S_IDLE) && !q_empty_i;
  assign ram_we  = (state_q == S_ACC);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      old_sum[c] = ram_rdata[(2-c)*SUM_W +: SUM_W];
      new_sum[c] = cur_flags.first ? SUM_W'(cur_pix[c])
                                   : old_sum[c] + SUM_W'(cur_pix[c]);
      trial[c]   = {rem_q[c][REM_W-2:0], sum_q[c][SUM_W-1]};
    end
  end

  bds_ram #(
    .WIDTH (3*SUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cur_addr),
    .wdata_i ({new_sum[0], new_sum[1], new_sum[2]}),
    .re_i    (q_pop_o),
    .raddr_i (q_data_i[3*PIX_W +: AW]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      cnt_q       <= '0;
      sat_q       <= '0;
      out_valid_q <= 1'b0;
      done_q      <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        sum_q[c] <= '0;
        rem_q[c] <= '0;
        quo_q[c] <= '0;
        out_q[c] <= '0;
      end
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            cur_q   <= q_data_i;
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          if (cur_flags.emit) begin
            for (int c = 0; c < 3; c++) begin
              // low byte moves to the top and is shifted in one bit a step
              sum_q[c] <= {new_sum[c][PIX_W-1:0], HI_W'(0)};
              rem_q[c] <= REM_W'(new_sum[c][SUM_W-1:PIX_W]);
              sat_q[c] <= REM_W'(new_sum[c][SUM_W-1:PIX_W]) >= area_ext;
              quo_q[c] <= '0;
            end
            cnt_q   <= CW'(PIX_W-1);
            state_q <= S_DIV;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_DIV: begin
          for (int c = 0; c < 3; c++) begin
            sum_q[c] <= sum_q[c] << 1;
            if (trial[c] >= area_ext) begin
              rem_q[c] <= trial[c] - area_ext;
              quo_q[c] <= {quo_q[c][PIX_W-2:0], 1'b1};
            end else begin
              rem_q[c] <= trial[c];
              quo_q[c] <= {quo_q[c][PIX_W-2:0], 1'b0};
            end
          end
          if (cnt_q == '0) begin
            state_q <= S_OUT;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            for (int c = 0; c < 3; c++) begin
              out_q[c] <= sat_q[c] ? '1 : quo_q[c];
            end
            done_q      <= cur_flags.done;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_out_o    = out_q[0];
  assign green_out_o  = out_q[1];
  assign blue_out_o   = out_q[2];
  assign frame_done_o = done_q;

`ifndef SYNTHESIS
  a_rem_below_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> ((sat_q[0] || rem_q[0] < area_ext)
                         && (sat_q[1] || rem_q[1] < area_ext)
                         && (sat_q[2] || rem_q[2] < area_ext)))
    else $error("divider remainder not below block area");

  a_write_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> $past(q_pop_o))
    else $error("sum write without a preceding read");

  a_div_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q == '0) |=> (state_q == S_OUT))
    else $error("divider did not finish after eight steps");
`endif

endmodule

// ===== rtl/core/box_downscale_rgb_core.sv =====
// an emitting pixel passes the queue, the sum read and write back, the 8-step
// bit-serial divider and the output state, which waits on out_stall_i, before its
// result is on the output register; the back pops a new pixel only when idle again
// pixels outside whole blocks are accepted by the front and dropped
// reset: counters clear; input stalls while block bounds are recomputed,
// and again after every configuration write
module box_downscale_rgb_core
  import bds_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_FACTOR = DEF_MAX_FACTOR
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bds_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bds_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [bds_pkg::PIX_W-1:0]       red_in_i,
  input  logic [bds_pkg::PIX_W-1:0]       green_in_i,
  input  logic [bds_pkg::PIX_W-1:0]       blue_in_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bds_pkg::PIX_W-1:0]       red_out_o,
  output logic [bds_pkg::PIX_W-1:0]       green_out_o,
  output logic [bds_pkg::PIX_W-1:0]       blue_out_o,
  output logic                            frame_done_o
);

  localparam int unsigned AW     = $clog2(MAX_WIDTH);
  localparam int unsigned EW     = FLAGS_W + AW + 3*PIX_W;
  localparam int unsigned AREA_W = 2*$clog2(MAX_FACTOR+1);

  logic              q_push, q_full, q_pop, q_empty;
  logic [EW-1:0]     q_wdata, q_rdata;
  logic [AREA_W-1:0] area;

  bds_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .red_in_i   (red_in_i),
    .green_in_i (green_in_i),
    .blue_in_i  (blue_in_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata),
    .area_o     (area)
  );

  bds_fifo #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  bds_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_data_i     (q_rdata),
    .q_pop_o      (q_pop),
    .area_i       (area),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o),
    .frame_done_o (frame_done_o)
  );

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import bds_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
    logic             done;
  } block_mean_t;

  // one directed row: either a setting change or a pixel
  typedef struct {
    bit                  is_cfg;
    logic [CFG_DATA_W-1:0] fac, wid, hgt;
    logic [PIX_W-1:0]    r, g, b;
    bit                  typed;
    block_mean_t         want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_FACTOR;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [PIX_W-1:0] red_in_i = '0, green_in_i = '0, blue_in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [PIX_W-1:0] red_out_o, green_out_o, blue_out_o;
  logic frame_done_o;

  box_downscale_rgb_core uut (.*);

  always #2 clk_i = ~clk_i;

  // block state mirror
  logic [4:0]  bx_factor;
  logic [12:0] bx_width, bx_height;
  int unsigned sum_r [4096], sum_g [4096], sum_b [4096];
  int unsigned col_idx, row_idx, col_blk, row_blk, out_col;

  block_mean_t pending_means[$];
  int errors = 0;
  int rx_count = 0;
  int burst_left = 0;

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic logic [7:0] sat_mean(int unsigned s, int unsigned area);
    int unsigned m;
    m = s / area;
    return (m > 255) ? 8'd255 : m[7:0];
  endfunction

  // advance the mirror by one pixel; returns 1 when a block mean comes out
  function bit average_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             output block_mean_t res);
    int unsigned f, w, h, uw, uh, oc;
    bit last_col, hit;
    f = clampu(bx_factor, 1, 16);
    w = clampu(bx_width, 1, 4096);
    h = clampu(bx_height, 1, HEIGHT_LIMIT);
    uw = (w / f) * f;
    uh = (h / f) * f;
    last_col = (col_blk + 1 >= f);
    hit = 0;
    res = '0;
    if (col_idx < uw && row_idx < uh && out_col < 4096) begin
      oc = out_col;
      if (row_blk == 0 && col_blk == 0) begin
        sum_r[oc] = r; sum_g[oc] = g; sum_b[oc] = b;
      end else begin
        sum_r[oc] += r; sum_g[oc] += g; sum_b[oc] += b;
      end
      if (row_blk + 1 >= f && last_col) begin
        res.r = sat_mean(sum_r[oc], f * f);
        res.g = sat_mean(sum_g[oc], f * f);
        res.b = sat_mean(sum_b[oc], f * f);
        res.done = (row_idx + 1 >= uh && col_idx + 1 >= uw);
        hit = 1;
      end
    end
    if (last_col) begin
      col_blk = 0;
      out_col++;
    end else begin
      col_blk++;
    end
    col_idx++;
    if (col_idx >= w) begin
      col_idx = 0; col_blk = 0; out_col = 0;
      row_blk = (row_blk + 1 >= f) ? 0 : row_blk + 1;
      row_idx++;
      if (row_idx >= h) begin
        row_idx = 0; row_blk = 0;
      end
    end
    if (out_col > 4096) out_col = 4096;
    return hit;
  endfunction

  task automatic write_settings(logic [12:0] fac, logic [12:0] wid, logic [12:0] hgt);
    in_valid_i <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
    // pixels that close no block may still be in flight
    repeat (40) @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= CFG_FACTOR; cfg_data_i <= fac;
    @(posedge clk_i);
    cfg_idx_i <= CFG_WIDTH; cfg_data_i <= wid;
    @(posedge clk_i);
    cfg_idx_i <= CFG_HEIGHT; cfg_data_i <= hgt;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    bx_factor = fac[4:0];
    bx_width = wid;
    bx_height = hgt;
  endtask

  // sends one pixel request, honoring bursts; predicted or typed result queued
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            bit typed, block_mean_t want);
    block_mean_t res;
    bit hit;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    red_in_i <= r; green_in_i <= g; blue_in_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    hit = average_pixel(r, g, b, res);
    if (typed) pending_means.push_back(want);
    else if (hit) pending_means.push_back(res);
  endtask

  task automatic send_frame(int unsigned n_px);
    logic [7:0] r, g, b;
    int sel;
    for (int unsigned i = 0; i < n_px; i++) begin
      sel = $urandom_range(0, 9);
      r = (sel == 0) ? 8'd255 : (sel == 1) ? 8'd0 : 8'($urandom);
      g = (sel == 0) ? 8'd255 : (sel == 1) ? 8'd0 : 8'($urandom);
      b = (sel == 0) ? 8'd255 : (sel == 1) ? 8'd0 : 8'($urandom);
      send_pixel(r, g, b, 0, '0);
    end
  endtask

  // receiver: compare and drive stall
  int stall_mode = 0, mode_left = 0, hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk_i) begin
    block_mean_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{red_out_o, green_out_o, blue_out_o, frame_done_o};
      rx_count++;
      if (pending_means.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result r=%0d g=%0d b=%0d done=%0b",
                                   got.r, got.g, got.b, got.done);
      end else begin
        want = pending_means.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: want r=%0d g=%0d b=%0d done=%0b, got r=%0d g=%0d b=%0d done=%0b",
                     want.r, want.g, want.b, want.done, got.r, got.g, got.b, got.done);
        end
      end
    end
    if (!hold_done && rx_count >= 30) begin
      hold_done <= 1;
      hold_left <= 600;
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(16, 96);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= $urandom_range(0, 1);
        default: out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  dir_row_t dir_rows[$];

  function automatic dir_row_t cfg_row(int fac, int wid, int hgt);
    dir_row_t d;
    d = '{default: 0};
    d.is_cfg = 1;
    d.fac = CFG_DATA_W'(fac); d.wid = CFG_DATA_W'(wid); d.hgt = CFG_DATA_W'(hgt);
    return d;
  endfunction

  function automatic dir_row_t px_row(int r, int g, int b, bit typed,
                                      int er, int eg, int eb, bit ed);
    dir_row_t d;
    d = '{default: 0};
    d.r = PIX_W'(r); d.g = PIX_W'(g); d.b = PIX_W'(b); d.typed = typed;
    d.want = '{PIX_W'(er), PIX_W'(eg), PIX_W'(eb), ed};
    return d;
  endfunction

  initial begin
    int unsigned f, w, h, n_rand;
    logic [12:0] fac_data;
    bx_factor = FACTOR_RST;
    bx_width = WIDTH_RST;
    bx_height = HEIGHT_RST;
    col_idx = 0; row_idx = 0; col_blk = 0; row_blk = 0; out_col = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // factor one: each pixel is its own mean
    dir_rows.push_back(cfg_row(1, 2, 2));
    dir_rows.push_back(px_row(0, 0, 0, 1, 0, 0, 0, 0));
    dir_rows.push_back(px_row(255, 255, 255, 1, 255, 255, 255, 0));
    dir_rows.push_back(px_row(1, 2, 3, 1, 1, 2, 3, 0));
    dir_rows.push_back(px_row(128, 64, 32, 1, 128, 64, 32, 1));
    // full-scale 2x2 block
    dir_rows.push_back(cfg_row(2, 2, 2));
    dir_rows.push_back(px_row(255, 255, 255, 0, 0, 0, 0, 0));
    dir_rows.push_back(px_row(255, 255, 255, 0, 0, 0, 0, 0));
    dir_rows.push_back(px_row(255, 255, 255, 0, 0, 0, 0, 0));
    dir_rows.push_back(px_row(255, 255, 255, 1, 255, 255, 255, 1));
    // zero factor and zero sizes act as one
    dir_rows.push_back(cfg_row(0, 0, 0));
    dir_rows.push_back(px_row(7, 8, 9, 1, 7, 8, 9, 1));
    // partial column and row dropped
    dir_rows.push_back(cfg_row(3, 4, 4));
    for (int i = 0; i < 16; i++)
      dir_rows.push_back(px_row(i * 16, 255 - i * 16, i * 7, 0, 0, 0, 0, 0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg)
        write_settings(dir_rows[i].fac, dir_rows[i].wid, dir_rows[i].hgt);
      else
        send_pixel(dir_rows[i].r, dir_rows[i].g, dir_rows[i].b,
                   dir_rows[i].typed, dir_rows[i].want);
    end

    // extremes: oversized factor, oversized width and height
    write_settings({8'hff, 5'd31}, 13'd16, 13'd16);
    send_frame(256);
    write_settings(13'd1, 13'd8191, 13'd1);
    send_frame(48);
    // close the partial row so the next frame starts aligned
    write_settings(13'd1, 13'd49, 13'd1);
    send_frame(1);
    write_settings(13'd1, 13'd1, 13'd8191);
    send_frame(48);
    write_settings(13'd1, 13'd1, 13'd49);
    send_frame(1);

    n_rand = 0;
    while (n_rand < 280) begin
      case ($urandom_range(0, 7))
        0: f = $urandom_range(5, 16);
        1: f = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(17, 31);
        default: f = $urandom_range(1, 4);
      endcase
      w = $urandom_range(1, 40);
      h = $urandom_range(1, 120 / w);
      fac_data = {8'($urandom), 5'(f)};
      write_settings(fac_data, 13'(w), 13'(h));
      repeat ($urandom_range(1, 2)) begin
        send_frame(w * h);
        n_rand += w * h;
      end
    end

    in_valid_i <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== box_downscale_rgb_core.f =====
rtl/core/bds_pkg.sv
rtl/core/bds_ram.sv
rtl/core/bds_fifo.sv
rtl/core/bds_front.sv
rtl/core/bds_back.sv
rtl/core/box_downscale_rgb_core.sv
tb/tb_top.sv
